/* design/csv_pkg.sv */
`timescale 1ns / 1ps
package csv_pkg;

   // Counter widths. The result fields are as wide as the counters.
   localparam int ROW_BITS    = 16;
   localparam int FIELD_BITS  = 10;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   typedef enum logic [2:0] {
      CLS_NEWLINE = 3'd0,
      CLS_COMMA   = 3'd1,
      CLS_QUOTE   = 3'd2,
      CLS_OTHER   = 3'd3,
      CLS_END     = 3'd4
   } class_type;

   typedef enum logic [1:0] {
      ST_RUNNING  = 2'd0,
      ST_DONE     = 2'd1,
      ST_SYNTAX   = 2'd2,
      ST_MISMATCH = 2'd3
   } status_type;

   // Parser phases. Only the first seven are ever stored; end and error
   // are outcomes of a transition.
   typedef enum logic [3:0] {
      PH_START       = 4'd0,
      PH_UNQUOTED    = 4'd1,
      PH_OPEN_QUOTE  = 4'd2,
      PH_QUOTED      = 4'd3,
      PH_QUOTE_CLOSE = 4'd4,
      PH_COMMA       = 4'd5,
      PH_NEWLINE     = 4'd6,
      PH_END         = 4'd7,
      PH_ERROR       = 4'd8
   } phase_type;

   localparam int NUM_PHASES  = 7;
   localparam int NUM_CLASSES = 5;

   // Rows: current phase. Columns: newline, comma, quote, other, end.
   localparam phase_type NEXT_PHASE_TABLE [NUM_PHASES][NUM_CLASSES] = '{
      '{PH_NEWLINE, PH_COMMA,  PH_OPEN_QUOTE,  PH_UNQUOTED, PH_END},
      '{PH_NEWLINE, PH_COMMA,  PH_UNQUOTED,    PH_UNQUOTED, PH_END},
      '{PH_QUOTED,  PH_QUOTED, PH_QUOTE_CLOSE, PH_QUOTED,   PH_ERROR},
      '{PH_QUOTED,  PH_QUOTED, PH_QUOTE_CLOSE, PH_QUOTED,   PH_ERROR},
      '{PH_NEWLINE, PH_COMMA,  PH_QUOTED,      PH_ERROR,    PH_END},
      '{PH_NEWLINE, PH_COMMA,  PH_OPEN_QUOTE,  PH_UNQUOTED, PH_END},
      '{PH_NEWLINE, PH_COMMA,  PH_OPEN_QUOTE,  PH_UNQUOTED, PH_END}
   };

   // Head of the class queue as seen by the back end.
   typedef struct packed {
      logic      valid;
      class_type cls;
   } queue_head_type;

   function automatic logic [ROW_BITS-1:0] inc_row(input logic [ROW_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [FIELD_BITS-1:0] inc_field(input logic [FIELD_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

/* design/csv_if.sv */
`timescale 1ns / 1ps
interface csv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface csv_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] row_count;
   logic [9:0]  field_count;
   logic [15:0] error_line;
   logic [15:0] error_column;

   modport source (output valid, output status, output row_count, output field_count,
                   output error_line, output error_column, input ready);
   modport sink   (input valid, input status, input row_count, input field_count,
                   input error_line, input error_column, output ready);
endinterface

/* design/csv_front.sv */
`timescale 1ns / 1ps
module csv_front import csv_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   csv_req_if.sink        req_chan,
   output queue_head_type head,
   input  logic           pop
);

   class_type             cls;
   class_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  push;
   logic                  do_pop;

   always_comb begin
      if (req_chan.end_of_text || req_chan.data_byte == CHAR_NUL) begin
         cls = CLS_END;
      end else if (req_chan.data_byte == CHAR_NEWLINE) begin
         cls = CLS_NEWLINE;
      end else if (req_chan.data_byte == CHAR_COMMA) begin
         cls = CLS_COMMA;
      end else if (req_chan.data_byte == CHAR_QUOTE) begin
         cls = CLS_QUOTE;
      end else begin
         cls = CLS_OTHER;
      end
   end

   assign req_chan.ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign do_pop         = pop && (count_ff != '0);
   assign head.valid     = (count_ff != '0);
   assign head.cls       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

/* design/csv_back.sv */
`timescale 1ns / 1ps
module csv_back import csv_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   csv_rsp_if.source      rsp_chan
);

   phase_type             phase_ff, phase_in;
   logic [ROW_BITS-1:0]   rows_ff, rows_in;
   logic [ROW_BITS-1:0]   line_ff, line_in;
   logic [ROW_BITS-1:0]   column_ff, column_in;
   logic [FIELD_BITS-1:0] first_ff, first_in;
   logic [FIELD_BITS-1:0] cur_ff, cur_in;

   logic                  out_valid_ff, out_valid_in;
   status_type            status_ff, status_in;
   logic [ROW_BITS-1:0]   row_count_ff, row_count_in;
   logic [FIELD_BITS-1:0] field_count_ff, field_count_in;
   logic [ROW_BITS-1:0]   err_line_ff, err_line_in;
   logic [ROW_BITS-1:0]   err_col_ff, err_col_in;

   phase_type             nx;
   logic                  is_end;
   logic                  rec_end;
   logic                  terminal;
   logic [ROW_BITS-1:0]   rows_b, line_b, col_b;
   logic [FIELD_BITS-1:0] cur_b, first_b;

   // The result register frees up in the same cycle it is taken.
   assign pop    = head.valid && (!out_valid_ff || rsp_chan.ready);
   assign is_end = (head.cls == CLS_END);
   assign nx     = NEXT_PHASE_TABLE[phase_ff[2:0]][head.cls];

   always_comb begin
      rows_b    = rows_ff;
      line_b    = line_ff;
      col_b     = column_ff;
      cur_b     = cur_ff;
      first_b   = first_ff;
      rec_end   = 1'b0;
      terminal  = 1'b0;
      status_in = ST_RUNNING;
      err_line_in = '0;
      err_col_in  = '0;

      if (is_end && phase_ff == PH_NEWLINE) begin
         // End right after a newline: the empty last line is not a record.
         terminal  = 1'b1;
         status_in = ST_DONE;
      end else begin
         if (is_end) begin
            rows_b = inc_row(rows_ff);
         end
         if (nx == PH_NEWLINE) begin
            rows_b = inc_row(rows_b);
            line_b = inc_row(line_ff);
            col_b  = ROW_BITS'(1);
         end else if (nx inside {[PH_UNQUOTED:PH_COMMA]}) begin
            col_b = inc_row(column_ff);
         end

         rec_end = (nx == PH_NEWLINE) || (nx == PH_END);
         if (rec_end || nx == PH_COMMA) begin
            cur_b = inc_field(cur_ff);
         end
         if (rec_end && first_ff == '0) begin
            first_b = cur_b;
         end

         if (rec_end && first_b != cur_b) begin
            terminal    = 1'b1;
            status_in   = ST_MISMATCH;
            err_line_in = line_b - 1'b1;
            err_col_in  = ROW_BITS'(1);
         end else if (nx == PH_ERROR) begin
            terminal    = 1'b1;
            status_in   = ST_SYNTAX;
            err_line_in = line_b;
            err_col_in  = col_b;
         end else if (nx == PH_END) begin
            terminal  = 1'b1;
            status_in = ST_DONE;
         end
      end

      row_count_in   = rows_b;
      field_count_in = first_b;
   end

   always_comb begin
      if (terminal) begin
         phase_in  = PH_START;
         rows_in   = '0;
         line_in   = ROW_BITS'(1);
         column_in = ROW_BITS'(1);
         first_in  = '0;
         cur_in    = '0;
      end else begin
         phase_in  = nx;
         rows_in   = rows_b;
         line_in   = line_b;
         column_in = col_b;
         first_in  = first_b;
         cur_in    = rec_end ? '0 : cur_b;
      end
   end

   always_comb begin
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         rows_ff      <= '0;
         line_ff      <= ROW_BITS'(1);
         column_ff    <= ROW_BITS'(1);
         first_ff     <= '0;
         cur_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            phase_ff  <= phase_in;
            rows_ff   <= rows_in;
            line_ff   <= line_in;
            column_ff <= column_in;
            first_ff  <= first_in;
            cur_ff    <= cur_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff      <= status_in;
         row_count_ff   <= row_count_in;
         field_count_ff <= field_count_in;
         err_line_ff    <= err_line_in;
         err_col_ff     <= err_col_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.row_count    = row_count_ff;
   assign rsp_chan.field_count  = field_count_ff;
   assign rsp_chan.error_line   = err_line_ff;
   assign rsp_chan.error_column = err_col_ff;

endmodule

/* design/csv_stream_validator.sv */
`timescale 1ns / 1ps
// CSV stream validator. Each request item carries one byte of text (or an end
// marker) and yields exactly one response item: running, done, syntax error
// with line and column, or field count mismatch. The block takes one item per
// clock and sustains that rate indefinitely as long as responses are taken;
// a request is first registered in the class queue, and the parser's phase
// and counter update, the loop that sets the rate, writes its response to the
// response register when the item is popped, which happens only while that
// register is empty or being taken. A two-entry queue between the byte
// classifier and the parser lets the request side keep going for up to two
// items while the response side stalls. After any terminal status the parser
// starts a new buffer on its own; no clearing pass is needed after reset.
module csv_stream_validator import csv_pkg::*; (
   input logic       clock,
   input logic       reset,
   csv_req_if.sink   req_chan,
   csv_rsp_if.source rsp_chan
);

   queue_head_type head;
   logic           pop;

   csv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head     (head),
      .pop      (pop)
   );

   csv_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

/* sim/tb_csv_stream_validator.sv */
`timescale 1ns / 1ps
module tb_csv_stream_validator;
   import csv_pkg::*;

   localparam int unsigned ROW_MAX   = (1 << ROW_BITS) - 1;
   localparam int unsigned FIELD_MAX = (1 << FIELD_BITS) - 1;
   localparam int RANDOM_ITEMS = 420;
   localparam int QUIET_TAIL   = 120;
   localparam int STALL_CYCLES = 60;

   // Next phase, indexed by current phase and byte class.
   localparam logic [3:0] PHASE_STEP [7][5] = '{
      '{PH_NEWLINE, PH_COMMA,  PH_OPEN_QUOTE,  PH_UNQUOTED, PH_END},
      '{PH_NEWLINE, PH_COMMA,  PH_UNQUOTED,    PH_UNQUOTED, PH_END},
      '{PH_QUOTED,  PH_QUOTED, PH_QUOTE_CLOSE, PH_QUOTED,   PH_ERROR},
      '{PH_QUOTED,  PH_QUOTED, PH_QUOTE_CLOSE, PH_QUOTED,   PH_ERROR},
      '{PH_NEWLINE, PH_COMMA,  PH_QUOTED,      PH_ERROR,    PH_END},
      '{PH_NEWLINE, PH_COMMA,  PH_OPEN_QUOTE,  PH_UNQUOTED, PH_END},
      '{PH_NEWLINE, PH_COMMA,  PH_OPEN_QUOTE,  PH_UNQUOTED, PH_END}
   };

   typedef struct packed {
      logic [7:0] data;
      logic       eot;
   } text_item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] rows;
      logic [9:0]  fields;
      logic [15:0] eline;
      logic [15:0] ecol;
   } csv_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csv_req_if req_if();
   csv_rsp_if rsp_if();

   csv_stream_validator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   text_item_type   text_q[$];
   csv_verdict_type verdict_q[$];
   int unsigned  total_items;
   int unsigned  accepted_items;
   int unsigned  checked_items;
   int unsigned  error_count;
   int unsigned  status_seen [4];
   bit           req_taken;
   int           send_gap;
   int           sink_gap;
   int           stall_left;
   bit           stall_done;

   // Parser state as the block should hold it.
   logic [3:0]   cur_phase;
   int unsigned  rows_seen;
   int unsigned  line_no;
   int unsigned  col_no;
   int unsigned  first_fields;
   int unsigned  cur_fields;

   function automatic int unsigned bump(input int unsigned v, input int unsigned max);
      return (v >= max) ? max : v + 1;
   endfunction

   function automatic void restart_parser();
      cur_phase    = PH_START;
      rows_seen    = 0;
      line_no      = 1;
      col_no       = 1;
      first_fields = 0;
      cur_fields   = 0;
   endfunction

   function automatic void predict_verdict(input logic [7:0] b, input logic eot);
      class_type       cls;
      logic [3:0]      ph;
      logic [3:0]      nx;
      bit              last;
      csv_verdict_type v;
      if (eot || b == CHAR_NUL) cls = CLS_END;
      else if (b == CHAR_NEWLINE) cls = CLS_NEWLINE;
      else if (b == CHAR_COMMA) cls = CLS_COMMA;
      else if (b == CHAR_QUOTE) cls = CLS_QUOTE;
      else cls = CLS_OTHER;
      ph = (cur_phase > PH_NEWLINE) ? PH_START : cur_phase;
      nx = ph;
      v.status = ST_RUNNING;
      v.eline  = '0;
      v.ecol   = '0;
      last     = 1'b1;
      // An end right after a newline closes the buffer without a new record.
      if (cls == CLS_END && ph == PH_NEWLINE) begin
         v.status = ST_DONE;
      end else begin
         if (cls == CLS_END) rows_seen = bump(rows_seen, ROW_MAX);
         nx = PHASE_STEP[ph[2:0]][cls];
         if (nx == PH_NEWLINE) begin
            rows_seen = bump(rows_seen, ROW_MAX);
            line_no   = bump(line_no, ROW_MAX);
            col_no    = 1;
         end else if (nx >= PH_UNQUOTED && nx <= PH_COMMA) begin
            col_no = bump(col_no, ROW_MAX);
         end
         if (nx == PH_NEWLINE || nx == PH_END) begin
            cur_fields = bump(cur_fields, FIELD_MAX);
            if (first_fields == 0) first_fields = cur_fields;
            if (first_fields != cur_fields) begin
               v.status = ST_MISMATCH;
               v.eline  = line_no - 1;
               v.ecol   = 1;
            end else begin
               cur_fields = 0;
            end
         end else if (nx == PH_COMMA) begin
            cur_fields = bump(cur_fields, FIELD_MAX);
         end
         if (v.status == ST_RUNNING) begin
            if (nx == PH_ERROR) begin
               v.status = ST_SYNTAX;
               v.eline  = line_no;
               v.ecol   = col_no;
            end else if (nx == PH_END) begin
               v.status = ST_DONE;
            end else begin
               last = 1'b0;
            end
         end
      end
      v.rows   = rows_seen;
      v.fields = first_fields;
      verdict_q.push_back(v);
      status_seen[v.status]++;
      if (last) restart_parser();
      else cur_phase = nx;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // Stimulus building.
   task automatic put(input logic [7:0] b, input logic eot);
      text_item_type t;
      t.data = b;
      t.eot  = eot;
      text_q.push_back(t);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
   endtask

   task automatic put_end(input bit as_nul);
      if (as_nul) put(CHAR_NUL, 1'b0);
      else put(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (b == CHAR_NEWLINE || b == CHAR_COMMA || b == CHAR_QUOTE);
      return b;
   endfunction

   task automatic add_field(input bit force_quote, input bit bad_close,
                            input bit no_close);
      int kind;
      int n;
      kind = force_quote ? 3 : $urandom_range(0, 3);
      if (kind == 1 || kind == 2) begin
         n = $urandom_range(1, 4);
         put(plain_byte(), 1'b0);
         // A quote past the first byte of an unquoted field is plain text.
         for (int i = 1; i < n; i++)
            put(($urandom_range(0, 5) == 0) ? CHAR_QUOTE : plain_byte(), 1'b0);
      end else if (kind == 3) begin
         put(CHAR_QUOTE, 1'b0);
         n = $urandom_range(0, 4);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
               0: begin
                  put(CHAR_QUOTE, 1'b0);
                  put(CHAR_QUOTE, 1'b0);
               end
               1: put(CHAR_NEWLINE, 1'b0);
               2: put(CHAR_COMMA, 1'b0);
               default: put(plain_byte(), 1'b0);
            endcase
         end
         if (!no_close) put(CHAR_QUOTE, 1'b0);
         if (bad_close) put(plain_byte(), 1'b0);
      end
   endtask

   task automatic add_random_buffer();
      int kind;
      int nrec;
      int nf;
      int width;
      int broken_rec;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 7))
               0: put(CHAR_NEWLINE, 1'b0);
               1: put(CHAR_COMMA, 1'b0);
               2: put(CHAR_QUOTE, 1'b0);
               3: put(8'($urandom_range(0, 255)), 1'b1);
               default: put(8'($urandom_range(0, 255)), 1'b0);
            endcase
         end
      end else begin
         nrec = $urandom_range(1, 4);
         nf   = $urandom_range(1, 4);
         broken_rec = (kind <= 2) ? $urandom_range(0, nrec - 1) : -1;
         for (int r = 0; r < nrec; r++) begin
            width = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : nf;
            for (int f = 0; f < width; f++) begin
               if (f > 0) put(CHAR_COMMA, 1'b0);
               if (r == broken_rec && f == width - 1)
                  add_field(1'b1, kind == 1, kind == 2);
               else
                  add_field(1'b0, 1'b0, 1'b0);
            end
            if (r < nrec - 1 || $urandom_range(0, 1)) put(CHAR_NEWLINE, 1'b0);
         end
      end
      put_end($urandom_range(0, 3) == 0);
   endtask

   // Request driver.
   always @(negedge clock) begin
      text_item_type nxt;
      bit            quiet;
      quiet = (text_q.size() < QUIET_TAIL);
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_taken) begin
         // Hold the offered item until it is taken.
      end else if (send_gap > 0) begin
         send_gap--;
         req_if.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         send_gap = $urandom_range(0, 8);
         req_if.valid <= 1'b0;
      end else if (text_q.size() > 0) begin
         nxt = text_q.pop_front();
         req_if.valid       <= 1'b1;
         req_if.data_byte   <= nxt.data;
         req_if.end_of_text <= nxt.eot;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // Response ready, with one long stall early on to back the block up.
   always @(negedge clock) begin
      bit quiet;
      quiet = (text_q.size() < QUIET_TAIL);
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (!stall_done && accepted_items >= 12) begin
         stall_done = 1'b1;
         stall_left = STALL_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap--;
         rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         sink_gap = $urandom_range(0, 8);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitor: predict on each accepted request, compare each accepted response.
   always @(posedge clock) begin
      csv_verdict_type v;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_if.valid && req_if.ready;
         if (req_taken) begin
            predict_verdict(req_if.data_byte, req_if.end_of_text);
            accepted_items++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            checked_items++;
            if (verdict_q.size() == 0) begin
               error_count++;
               $error("response item with no request pending");
            end else begin
               v = verdict_q.pop_front();
               check_field("status", v.status, rsp_if.status);
               check_field("row_count", v.rows, rsp_if.row_count);
               check_field("field_count", v.fields, rsp_if.field_count);
               check_field("error_line", v.eline, rsp_if.error_line);
               check_field("error_column", v.ecol, rsp_if.error_column);
            end
         end
      end
   end

   initial begin
      int start_size;
      req_if.valid       = 1'b0;
      req_if.data_byte   = 8'h00;
      req_if.end_of_text = 1'b0;
      rsp_if.ready       = 1'b0;
      accepted_items = 0;
      checked_items  = 0;
      error_count    = 0;
      send_gap   = 0;
      sink_gap   = 0;
      stall_left = 0;
      stall_done = 1'b0;
      req_taken  = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
      restart_parser();

      // Empty buffer.
      put_end(1'b0);
      // Empty last field, then a NUL right after the newline.
      put_text("a,\n");
      put_end(1'b1);
      // Quoted field made only of a doubled quote.
      put_text("\"\"\"\",b");
      put_end(1'b0);
      // Quote inside an unquoted field, with extreme byte values.
      put(8'hFF, 1'b0);
      put(CHAR_QUOTE, 1'b0);
      put(8'h01, 1'b0);
      put_end(1'b0);
      // End inside a quoted field.
      put_text("\"x");
      put_end(1'b0);
      // Text right after a closing quote.
      put_text("\"\"x");
      // Second record longer than the first.
      put_text("a\nb,c");
      put_end(1'b1);

      start_size = text_q.size();
      while (text_q.size() - start_size < RANDOM_ITEMS) add_random_buffer();
      total_items = text_q.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (accepted_items == total_items);
      wait (verdict_q.size() == 0);
      repeat (8) @(posedge clock);

      $display("Checked %0d responses over %0d buffers: %0d done, %0d syntax errors,",
               checked_items, status_seen[ST_DONE] + status_seen[ST_SYNTAX]
               + status_seen[ST_MISMATCH], status_seen[ST_DONE], status_seen[ST_SYNTAX]);
      $display("%0d field count mismatches, quoting corner cases and a %0d-cycle stall.",
               status_seen[ST_MISMATCH], STALL_CYCLES);
      if (error_count == 0) begin
         $display("tb_csv_stream_validator: done, clean");
      end else begin
         $display("tb_csv_stream_validator: done, errors");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("tb_csv_stream_validator: done, errors");
      $finish;
   end

endmodule
